>>> rtl/core/seat_occupancy_sensor_fusion_macros.svh
// ----------------------------------------------------------------------------
// Seat occupancy sensor fusion assertion macros
// Shorthands for clocked implication checks with a disable condition.
// ----------------------------------------------------------------------------
`ifndef SEAT_OCCUPANCY_SENSOR_FUSION_MACROS_SVH
`define SEAT_OCCUPANCY_SENSOR_FUSION_MACROS_SVH

// same-cycle implication
`define SOF_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sof: same-cycle check failed");

// next-cycle implication
`define SOF_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sof: next-cycle check failed");

`endif

>>> rtl/core/sof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_pkg
// Widths, register codes, reset values and stage payload types shared by the
// seat occupancy sensor fusion block.
// ----------------------------------------------------------------------------
package sof_pkg;

    // field widths
    localparam int SONAR_MM_W = 12;
    localparam int TOF_MM_W   = 16;
    localparam int ADC_W      = 12;
    localparam int UCM_W      = 9;
    localparam int TCM_W      = 13;
    localparam int GRAM_W     = 14;
    localparam int SCORE_W    = 3;
    localparam int WEIGHT_W   = 4;
    localparam int SUM_W      = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_PRESS  = 3;

    localparam int RUN_BITS_DEFAULT = 8;

    // scaling constants
    localparam int ADC_FULL  = 4095;
    localparam int GRAM_FULL = 10000;

    // largest values the filtered outputs can take
    localparam int SONAR_CM_MAX = 409;
    localparam int TOF_CM_MAX   = 6553;
    localparam int SUM_MAX      = 225;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_CONFIRM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_CONFIRM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ULTRA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TOF       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PRESS     = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0]    RST_ABSENT_THRESHOLD = 8'd10;
    localparam logic [CFG_W-1:0]    RST_PRESENT_CONFIRM  = 8'd3;
    localparam logic [CFG_W-1:0]    RST_ABSENT_CONFIRM   = 8'd3;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ULTRA     = 4'd3;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_TOF       = 4'd3;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_PRESS     = 4'd4;

    // band scores
    localparam logic [SCORE_W-1:0] SCORE_NONE = 3'd0;
    localparam logic [SCORE_W-1:0] SCORE_LOW  = 3'd1;
    localparam logic [SCORE_W-1:0] SCORE_MID  = 3'd3;
    localparam logic [SCORE_W-1:0] SCORE_HIGH = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0]    absent_threshold;
        logic [CFG_W-1:0]    present_confirm;
        logic [CFG_W-1:0]    absent_confirm;
        logic [WEIGHT_W-1:0] weight_ultra;
        logic [WEIGHT_W-1:0] weight_tof;
        logic [WEIGHT_W-1:0] weight_press;
    } t_cfg;

    // one raw request as captured at the input
    typedef struct packed {
        logic [SONAR_MM_W-1:0]           sonar_mm;
        logic [TOF_MM_W-1:0]             tof_mm;
        logic [NUM_PRESS-1:0][ADC_W-1:0] press_raw;
        logic [NUM_PRESS-1:0]            press_valid;
    } t_sample;

    // values in engineering units
    typedef struct packed {
        logic [ADC_W-1:0]  avg;
        logic [UCM_W-1:0]  sonar_cm;
        logic [TCM_W-1:0]  tof_cm;
        logic [GRAM_W-1:0] grams;
    } t_meas;

    // filtered values, scores and score sum
    typedef struct packed {
        logic [UCM_W-1:0]   ultra_f;
        logic [TCM_W-1:0]   tof_f;
        logic [GRAM_W-1:0]  press_f;
        logic [SCORE_W-1:0] score_u;
        logic [SCORE_W-1:0] score_t;
        logic [SCORE_W-1:0] score_p;
        logic [SUM_W-1:0]   wsum;
        logic [ADC_W-1:0]   avg;
    } t_filt;

endpackage

>>> rtl/core/sof_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_convert
// Holds the last valid pressure samples, averages them, and converts the
// distances to centimetres and the pressure average to grams in two stages.
// ----------------------------------------------------------------------------
module sof_convert
    import sof_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sample i_sample,
    output logic    o_ready,
    output logic    o_valid,
    output t_meas   o_meas,
    input  logic    i_ready
);

    // (n / 3) for n below 2^15: reciprocal estimate, one correction step
    function automatic logic [ADC_W-1:0] div3(input logic [14:0] n);
        logic [30:0] prod;
        logic [14:0] q0;
        logic [14:0] rem;
        prod = 31'(n) * 31'd21845;
        q0   = prod[30:16];
        rem  = n - 15'(q0 * 15'd3);
        if (rem >= 15'd3) begin
            q0 = q0 + 15'd1;
        end
        return q0[ADC_W-1:0];
    endfunction

    // (x / 10) for a 16-bit x: reciprocal estimate, one correction step
    function automatic logic [TCM_W-1:0] div10(input logic [15:0] x);
        logic [30:0] prod;
        logic [13:0] q0;
        logic [15:0] rem;
        prod = 31'(x) * 31'd13107;
        q0   = prod[30:17];
        rem  = x - 16'({2'b00, q0} * 16'd10);
        if (rem >= 16'd10) begin
            q0 = q0 + 14'd1;
        end
        return q0[TCM_W-1:0];
    endfunction

    // avg * 10000 / 4095, truncated; 1/4095 as a 4096-based series
    function automatic logic [GRAM_W-1:0] to_grams(input logic [ADC_W-1:0] avg);
        logic [25:0] x;
        logic [26:0] t;
        logic [14:0] q0;
        logic [26:0] rem;
        x   = 26'(avg) * 26'(GRAM_FULL);
        t   = 27'(x) + 27'(x[25:12]) + 27'(x[25:24]);
        q0  = t[26:12];
        rem = 27'(x) - {q0, 12'b0} + 27'(q0);
        if (rem >= 27'(ADC_FULL)) begin
            q0 = q0 + 15'd1;
        end
        return q0[GRAM_W-1:0];
    endfunction

    logic [NUM_PRESS-1:0][ADC_W-1:0] r_held;
    logic [NUM_PRESS-1:0][ADC_W-1:0] n_held;
    logic                            r_s1_valid;
    logic [ADC_W-1:0]                r_s1_avg;
    logic [UCM_W-1:0]                r_s1_ucm;
    logic [TCM_W-1:0]                r_s1_tcm;
    logic                            r_s2_valid;
    t_meas                           r_s2;
    logic [13:0]                     held_sum;
    logic                            s1_ready;
    logic                            s2_ready;
    logic                            s1_load;
    logic                            s2_load;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign s1_load  = i_valid && s1_ready;
    assign s2_load  = r_s1_valid && s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_s2_valid;
    assign o_meas   = r_s2;

    // sample hold: a channel keeps its last valid sample
    always_comb begin
        for (int k = 0; k < NUM_PRESS; k++) begin
            n_held[k] = i_sample.press_valid[k] ? i_sample.press_raw[k] : r_held[k];
        end
        held_sum = 14'(n_held[0]) + 14'(n_held[1]) + 14'(n_held[2]);
    end

    // stage one control and held samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_held     <= '0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
            if (i_valid) begin
                r_held <= n_held;
            end
        end
    end

    // stage one payload: rounded average and centimetres
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_avg <= div3(15'(held_sum) + 15'd1);
            r_s1_ucm <= UCM_W'(div10(16'(i_sample.sonar_mm)));
            r_s1_tcm <= div10(i_sample.tof_mm);
        end
    end

    // stage two control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage two payload: grams
    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2.avg      <= r_s1_avg;
            r_s2.sonar_cm <= r_s1_ucm;
            r_s2.tof_cm   <= r_s1_tcm;
            r_s2.grams    <= to_grams(r_s1_avg);
        end
    end

endmodule

>>> rtl/core/sof_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_filter
// Three-deep median windows per sensor, band scoring and the weighted score
// sum.
// ----------------------------------------------------------------------------
module sof_filter
    import sof_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_meas i_meas,
    output logic  o_ready,
    output logic  o_valid,
    output t_filt o_filt,
    input  logic  i_ready
);

    // median of three
    function automatic logic [GRAM_W-1:0] mid3(
        input logic [GRAM_W-1:0] a,
        input logic [GRAM_W-1:0] b,
        input logic [GRAM_W-1:0] c
    );
        logic [GRAM_W-1:0] lo;
        logic [GRAM_W-1:0] hi;
        logic [GRAM_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    function automatic logic [SCORE_W-1:0] band_ultra(input logic [UCM_W-1:0] cm);
        if (cm < 9'd2) begin
            return SCORE_NONE;
        end else if (cm < 9'd8) begin
            return SCORE_HIGH;
        end else if (cm < 9'd12) begin
            return SCORE_MID;
        end else if (cm < 9'd15) begin
            return SCORE_LOW;
        end
        return SCORE_NONE;
    endfunction

    function automatic logic [SCORE_W-1:0] band_tof(input logic [TCM_W-1:0] cm);
        if (cm < 13'd5) begin
            return SCORE_NONE;
        end else if (cm < 13'd13) begin
            return SCORE_HIGH;
        end else if (cm < 13'd16) begin
            return SCORE_MID;
        end else if (cm < 13'd18) begin
            return SCORE_LOW;
        end
        return SCORE_NONE;
    endfunction

    function automatic logic [SCORE_W-1:0] band_press(input logic [GRAM_W-1:0] g);
        if (g < 14'd200) begin
            return SCORE_NONE;
        end else if (g < 14'd2000) begin
            return SCORE_LOW;
        end else if (g < 14'd4000) begin
            return SCORE_MID;
        end
        return SCORE_HIGH;
    endfunction

    logic [2:0][UCM_W-1:0]  r_uwin;
    logic [2:0][TCM_W-1:0]  r_twin;
    logic [2:0][GRAM_W-1:0] r_pwin;
    logic [1:0]             r_slot;
    logic [2:0][UCM_W-1:0]  n_uwin;
    logic [2:0][TCM_W-1:0]  n_twin;
    logic [2:0][GRAM_W-1:0] n_pwin;
    logic [1:0]             n_slot;
    logic [1:0]             cur_slot;
    logic                   r_valid;
    t_filt                  r_filt;
    t_filt                  n_filt;
    logic                   ready_up;
    logic                   load;

    assign ready_up = !r_valid || i_ready;
    assign load     = i_valid && ready_up;
    assign o_ready  = ready_up;
    assign o_valid  = r_valid;
    assign o_filt   = r_filt;

    // window write at the current slot, slot steps 0, 1, 2
    always_comb begin
        cur_slot = (r_slot == 2'd3) ? 2'd0 : r_slot;
        n_slot   = (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
        n_uwin   = r_uwin;
        n_twin   = r_twin;
        n_pwin   = r_pwin;
        for (int k = 0; k < 3; k++) begin
            if (cur_slot == 2'(k)) begin
                n_uwin[k] = i_meas.sonar_cm;
                n_twin[k] = i_meas.tof_cm;
                n_pwin[k] = i_meas.grams;
            end
        end
    end

    // medians, scores and weighted sum
    always_comb begin
        n_filt.ultra_f = UCM_W'(mid3(GRAM_W'(n_uwin[0]), GRAM_W'(n_uwin[1]),
                                     GRAM_W'(n_uwin[2])));
        n_filt.tof_f   = TCM_W'(mid3(GRAM_W'(n_twin[0]), GRAM_W'(n_twin[1]),
                                     GRAM_W'(n_twin[2])));
        n_filt.press_f = mid3(n_pwin[0], n_pwin[1], n_pwin[2]);
        n_filt.score_u = band_ultra(n_filt.ultra_f);
        n_filt.score_t = band_tof(n_filt.tof_f);
        n_filt.score_p = band_press(n_filt.press_f);
        n_filt.wsum    = SUM_W'(i_cfg.weight_ultra) * SUM_W'(n_filt.score_u)
                       + SUM_W'(i_cfg.weight_tof) * SUM_W'(n_filt.score_t)
                       + SUM_W'(i_cfg.weight_press) * SUM_W'(n_filt.score_p);
        n_filt.avg     = i_meas.avg;
    end

    // windows and stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_uwin  <= '0;
            r_twin  <= '0;
            r_pwin  <= '0;
            r_slot  <= 2'd0;
        end else if (ready_up) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_uwin <= n_uwin;
                r_twin <= n_twin;
                r_pwin <= n_pwin;
                r_slot <= n_slot;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_filt <= n_filt;
        end
    end

endmodule

>>> rtl/core/sof_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_decide
// Threshold compare, saturating seated and absent run counters, confirmed
// state, and the output register of the block.
// ----------------------------------------------------------------------------
module sof_decide
    import sof_pkg::*;
#(
    parameter int RUN_COUNTER_BITS = RUN_BITS_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_filt i_filt,
    output logic  o_ready,
    output logic  o_valid,
    output logic  o_seated,
    output t_filt o_filt,
    input  logic  i_ready
);

    localparam int CMP_W = (RUN_COUNTER_BITS > CFG_W) ? RUN_COUNTER_BITS : CFG_W;
    localparam logic [RUN_COUNTER_BITS-1:0] RUN_MAX = '1;

    logic [RUN_COUNTER_BITS-1:0] r_seat_run;
    logic [RUN_COUNTER_BITS-1:0] r_abs_run;
    logic [RUN_COUNTER_BITS-1:0] n_seat_run;
    logic [RUN_COUNTER_BITS-1:0] n_abs_run;
    logic                        r_conf;
    logic                        n_conf;
    logic                        r_valid;
    t_filt                       r_filt;
    logic                        seated_tick;
    logic                        ready_up;

    assign ready_up = !r_valid || i_ready;
    assign o_ready  = ready_up;
    assign o_valid  = r_valid;
    assign o_seated = r_conf;
    assign o_filt   = r_filt;

    // run counters; seated confirmation has priority
    always_comb begin
        seated_tick = i_filt.wsum > i_cfg.absent_threshold;
        if (seated_tick) begin
            n_seat_run = (r_seat_run == RUN_MAX) ? r_seat_run : r_seat_run + 1'b1;
            n_abs_run  = '0;
        end else begin
            n_seat_run = '0;
            n_abs_run  = (r_abs_run == RUN_MAX) ? r_abs_run : r_abs_run + 1'b1;
        end
        if (CMP_W'(n_seat_run) >= CMP_W'(i_cfg.present_confirm)) begin
            n_conf = 1'b1;
        end else if (CMP_W'(n_abs_run) >= CMP_W'(i_cfg.absent_confirm)) begin
            n_conf = 1'b0;
        end else begin
            n_conf = r_conf;
        end
    end

    // decision state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_seat_run <= '0;
            r_abs_run  <= '0;
            r_conf     <= 1'b0;
        end else if (ready_up) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_seat_run <= n_seat_run;
                r_abs_run  <= n_abs_run;
                r_conf     <= n_conf;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_valid && ready_up) begin
            r_filt <= i_filt;
        end
    end

endmodule

>>> rtl/core/seat_occupancy_sensor_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_occupancy_sensor_fusion
// Fuses ultrasonic, time-of-flight and pressure readings into a confirmed
// driver seated / absent decision.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (i_valid / o_ready) takes one request per sensor tick: two
//   distances in mm and three pressure ADC samples with their valid flags.
// - Output channel (o_valid / i_ready) returns one result per request, in
//   order: confirmed state, weighted score sum, filtered values, band scores
//   and the rounded pressure average.
// - Configuration channel (i_cfg_valid / o_cfg_ready) writes one register per
//   request by index; it is always ready. Write only while the block is idle.
// - Throughput is one request per cycle while i_ready stays high, through the
//   five register levels: input, average and cm, grams, median and scoring,
//   decision.
// - Each stage holds its request when the next one is full, so a stalled
//   receiver backs the pipeline up stage by stage before o_ready drops.
// - Reset clears the pipeline, the held samples, median windows, run counters
//   (driver absent) and loads the register defaults.
// ----------------------------------------------------------------------------
module seat_occupancy_sensor_fusion
    import sof_pkg::*;
#(
    parameter int RUN_COUNTER_BITS = RUN_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input requests
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SONAR_MM_W-1:0] i_sonar_mm,
    input  logic [TOF_MM_W-1:0]   i_tof_mm,
    input  logic [ADC_W-1:0]      i_press_raw_a,
    input  logic                  i_press_valid_a,
    input  logic [ADC_W-1:0]      i_press_raw_b,
    input  logic                  i_press_valid_b,
    input  logic [ADC_W-1:0]      i_press_raw_c,
    input  logic                  i_press_valid_c,
    // results
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_seat_occupied,
    output logic [SUM_W-1:0]      o_weighted_sum,
    output logic [UCM_W-1:0]      o_sonar_cm_filtered,
    output logic [TCM_W-1:0]      o_tof_cm_filtered,
    output logic [GRAM_W-1:0]     o_press_g_filtered,
    output logic [SCORE_W-1:0]    o_score_ultra_out,
    output logic [SCORE_W-1:0]    o_score_tof_out,
    output logic [SCORE_W-1:0]    o_score_press_out,
    output logic [ADC_W-1:0]      o_press_adc_average
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_sample r_in;
    logic    conv_ready;
    logic    conv_valid;
    t_meas   conv_meas;
    logic    filt_ready;
    logic    filt_valid;
    t_filt   filt_data;
    logic    dec_ready;
    t_filt   out_filt;
    logic    in_ready;

    assign o_cfg_ready = 1'b1;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.absent_threshold <= RST_ABSENT_THRESHOLD;
            r_cfg.present_confirm  <= RST_PRESENT_CONFIRM;
            r_cfg.absent_confirm   <= RST_ABSENT_CONFIRM;
            r_cfg.weight_ultra     <= RST_WEIGHT_ULTRA;
            r_cfg.weight_tof       <= RST_WEIGHT_TOF;
            r_cfg.weight_press     <= RST_WEIGHT_PRESS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ABSENT_THRESHOLD: r_cfg.absent_threshold <= i_cfg_data;
                CFG_PRESENT_CONFIRM:  r_cfg.present_confirm  <= i_cfg_data;
                CFG_ABSENT_CONFIRM:   r_cfg.absent_confirm   <= i_cfg_data;
                CFG_WEIGHT_ULTRA:     r_cfg.weight_ultra     <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_TOF:       r_cfg.weight_tof       <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_PRESS:     r_cfg.weight_press     <= i_cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    assign in_ready = !r_in_valid || conv_ready;
    assign o_ready  = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_in.sonar_mm       <= i_sonar_mm;
            r_in.tof_mm         <= i_tof_mm;
            r_in.press_raw[0]   <= i_press_raw_a;
            r_in.press_raw[1]   <= i_press_raw_b;
            r_in.press_raw[2]   <= i_press_raw_c;
            r_in.press_valid[0] <= i_press_valid_a;
            r_in.press_valid[1] <= i_press_valid_b;
            r_in.press_valid[2] <= i_press_valid_c;
        end
    end

    sof_convert u_convert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_sample (r_in),
        .o_ready  (conv_ready),
        .o_valid  (conv_valid),
        .o_meas   (conv_meas),
        .i_ready  (filt_ready)
    );

    sof_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (conv_valid),
        .i_meas   (conv_meas),
        .o_ready  (filt_ready),
        .o_valid  (filt_valid),
        .o_filt   (filt_data),
        .i_ready  (dec_ready)
    );

    sof_decide #(
        .RUN_COUNTER_BITS (RUN_COUNTER_BITS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (filt_valid),
        .i_filt   (filt_data),
        .o_ready  (dec_ready),
        .o_valid  (o_valid),
        .o_seated (o_seat_occupied),
        .o_filt   (out_filt),
        .i_ready  (i_ready)
    );

    assign o_weighted_sum      = out_filt.wsum;
    assign o_sonar_cm_filtered = out_filt.ultra_f;
    assign o_tof_cm_filtered   = out_filt.tof_f;
    assign o_press_g_filtered  = out_filt.press_f;
    assign o_score_ultra_out   = out_filt.score_u;
    assign o_score_tof_out     = out_filt.score_t;
    assign o_score_press_out   = out_filt.score_p;
    assign o_press_adc_average = out_filt.avg;

endmodule

>>> rtl/core/sof_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_checker
// Port-level checks on the seat occupancy sensor fusion block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "seat_occupancy_sensor_fusion_macros.svh"

module sof_checker
    import sof_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_seat_occupied,
    input logic [SUM_W-1:0]      o_weighted_sum,
    input logic [UCM_W-1:0]      o_sonar_cm_filtered,
    input logic [TCM_W-1:0]      o_tof_cm_filtered,
    input logic [GRAM_W-1:0]     o_press_g_filtered,
    input logic [SCORE_W-1:0]    o_score_ultra_out,
    input logic [SCORE_W-1:0]    o_score_tof_out,
    input logic [SCORE_W-1:0]    o_score_press_out,
    input logic [ADC_W-1:0]      o_press_adc_average
);

    // one of the four band levels
    function automatic logic score_ok(input logic [SCORE_W-1:0] s);
        return (s == SCORE_NONE) || (s == SCORE_LOW) || (s == SCORE_MID) ||
               (s == SCORE_HIGH);
    endfunction

    // reset empties the pipeline
    `SOF_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid)

    // a stalled result stays put
    `SOF_ASSERT_NXT(a_stall_hold, i_clk, !i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_seat_occupied) && $stable(o_weighted_sum) &&
        $stable(o_press_adc_average))

    // band scores take only their four levels
    `SOF_ASSERT_IMP(a_score_levels, i_clk, !i_rst_n, o_valid,
        score_ok(o_score_ultra_out) && score_ok(o_score_tof_out) &&
        score_ok(o_score_press_out))

    // converted values stay within the scale of their sensors
    `SOF_ASSERT_IMP(a_value_range, i_clk, !i_rst_n, o_valid,
        o_sonar_cm_filtered <= UCM_W'(SONAR_CM_MAX) &&
        o_tof_cm_filtered <= TCM_W'(TOF_CM_MAX) &&
        o_press_g_filtered <= GRAM_W'(GRAM_FULL) && o_weighted_sum <= SUM_W'(SUM_MAX))

endmodule

bind seat_occupancy_sensor_fusion sof_checker u_sof_checker (.*);

>>> verif/seat_occupancy_sensor_fusion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_occupancy_sensor_fusion_checker
// Watches the configuration, request and result channels of the seat
// occupancy fusion block. It keeps its own copy of the held pressure samples,
// median windows, run counters and registers. It predicts every result and
// compares it, field by field, with what the block returns.
// ----------------------------------------------------------------------------
module seat_occupancy_sensor_fusion_checker
    import sof_pkg::*;
#(
    parameter int RUN_COUNTER_BITS = RUN_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SONAR_MM_W-1:0] i_sonar_mm,
    input  logic [TOF_MM_W-1:0]   i_tof_mm,
    input  logic [ADC_W-1:0]      i_press_raw_a,
    input  logic                  i_press_valid_a,
    input  logic [ADC_W-1:0]      i_press_raw_b,
    input  logic                  i_press_valid_b,
    input  logic [ADC_W-1:0]      i_press_raw_c,
    input  logic                  i_press_valid_c,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_seat_occupied,
    input  logic [SUM_W-1:0]      i_weighted_sum,
    input  logic [UCM_W-1:0]      i_sonar_cm_filtered,
    input  logic [TCM_W-1:0]      i_tof_cm_filtered,
    input  logic [GRAM_W-1:0]     i_press_g_filtered,
    input  logic [SCORE_W-1:0]    i_score_ultra_out,
    input  logic [SCORE_W-1:0]    i_score_tof_out,
    input  logic [SCORE_W-1:0]    i_score_press_out,
    input  logic [ADC_W-1:0]      i_press_adc_average,
    // status to the test top
    output int                    o_failures,
    output int                    o_pending
);

    typedef struct packed {
        logic               seated;
        logic [SUM_W-1:0]   wsum;
        logic [UCM_W-1:0]   ultra_f;
        logic [TCM_W-1:0]   tof_f;
        logic [GRAM_W-1:0]  press_f;
        logic [SCORE_W-1:0] score_u;
        logic [SCORE_W-1:0] score_t;
        logic [SCORE_W-1:0] score_p;
        logic [ADC_W-1:0]   avg;
    } t_fusion_result;

    // shadow of the block's registers and state
    t_cfg                        cfg;
    logic [ADC_W-1:0]            held_sample [NUM_PRESS];
    logic [UCM_W-1:0]            ultra_win [3];
    logic [TCM_W-1:0]            tof_win [3];
    logic [GRAM_W-1:0]           press_win [3];
    logic [1:0]                  win_slot;
    logic [RUN_COUNTER_BITS-1:0] seated_run;
    logic [RUN_COUNTER_BITS-1:0] absent_run;
    logic                        seated_state;

    t_fusion_result fused_q [$];
    t_fusion_result want;
    t_fusion_result fresh;
    t_sample        req;
    int unsigned    result_count;

    initial begin
        o_failures   = 0;
        o_pending    = 0;
        result_count = 0;
    end

    function automatic int unsigned median3(input int unsigned a, input int unsigned b,
                                            input int unsigned c);
        int unsigned lo;
        int unsigned hi;
        int unsigned m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    function automatic logic [SCORE_W-1:0] ultra_band(input int unsigned cm);
        if (cm < 2)  return SCORE_NONE;
        if (cm < 8)  return SCORE_HIGH;
        if (cm < 12) return SCORE_MID;
        if (cm < 15) return SCORE_LOW;
        return SCORE_NONE;
    endfunction

    function automatic logic [SCORE_W-1:0] tof_band(input int unsigned cm);
        if (cm < 5)  return SCORE_NONE;
        if (cm < 13) return SCORE_HIGH;
        if (cm < 16) return SCORE_MID;
        if (cm < 18) return SCORE_LOW;
        return SCORE_NONE;
    endfunction

    function automatic logic [SCORE_W-1:0] press_band(input int unsigned grams);
        if (grams < 200)  return SCORE_NONE;
        if (grams < 2000) return SCORE_LOW;
        if (grams < 4000) return SCORE_MID;
        return SCORE_HIGH;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        o_failures++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s: got %0d, wanted %0d",
                                      result_count, field, got, exp_val));
    endtask

    // advance the shadow state by one request and work out its result
    task automatic fuse_sample(input t_sample s, output t_fusion_result r);
        int unsigned                 total;
        int unsigned                 avg;
        int unsigned                 grams;
        int unsigned                 cur;
        int unsigned                 uf;
        int unsigned                 tf;
        int unsigned                 pf;
        int unsigned                 ws;
        logic [SCORE_W-1:0]          su;
        logic [SCORE_W-1:0]          st;
        logic [SCORE_W-1:0]          sp;
        logic [RUN_COUNTER_BITS-1:0] run_max;
        run_max = '1;

        // each channel keeps its last valid sample
        for (int k = 0; k < NUM_PRESS; k++)
            if (s.press_valid[k]) held_sample[k] = s.press_raw[k];

        total = held_sample[0] + held_sample[1] + held_sample[2];
        avg   = (total + 1) / 3;
        grams = (avg * GRAM_FULL) / ADC_FULL;

        // three-deep windows, written round robin
        cur = (win_slot < 3) ? win_slot : 0;
        ultra_win[cur] = UCM_W'(s.sonar_mm / 10);
        tof_win[cur]   = TCM_W'(s.tof_mm / 10);
        press_win[cur] = GRAM_W'(grams);
        win_slot = (cur >= 2) ? 2'd0 : 2'(cur + 1);

        uf = median3(ultra_win[0], ultra_win[1], ultra_win[2]);
        tf = median3(tof_win[0], tof_win[1], tof_win[2]);
        pf = median3(press_win[0], press_win[1], press_win[2]);

        su = ultra_band(uf);
        st = tof_band(tf);
        sp = press_band(pf);
        ws = cfg.weight_ultra * su + cfg.weight_tof * st + cfg.weight_press * sp;

        // saturating runs; seated confirmation wins
        if (ws > cfg.absent_threshold) begin
            if (seated_run < run_max) seated_run++;
            absent_run = '0;
        end else begin
            if (absent_run < run_max) absent_run++;
            seated_run = '0;
        end
        if (seated_run >= cfg.present_confirm)
            seated_state = 1'b1;
        else if (absent_run >= cfg.absent_confirm)
            seated_state = 1'b0;

        r.seated  = seated_state;
        r.wsum    = SUM_W'(ws);
        r.ultra_f = UCM_W'(uf);
        r.tof_f   = TCM_W'(tf);
        r.press_f = GRAM_W'(pf);
        r.score_u = su;
        r.score_t = st;
        r.score_p = sp;
        r.avg     = ADC_W'(avg);
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.absent_threshold = RST_ABSENT_THRESHOLD;
            cfg.present_confirm  = RST_PRESENT_CONFIRM;
            cfg.absent_confirm   = RST_ABSENT_CONFIRM;
            cfg.weight_ultra     = RST_WEIGHT_ULTRA;
            cfg.weight_tof       = RST_WEIGHT_TOF;
            cfg.weight_press     = RST_WEIGHT_PRESS;
            for (int k = 0; k < 3; k++) begin
                held_sample[k] = '0;
                ultra_win[k]   = '0;
                tof_win[k]     = '0;
                press_win[k]   = '0;
            end
            win_slot     = '0;
            seated_run   = '0;
            absent_run   = '0;
            seated_state = 1'b0;
            fused_q.delete();
        end else begin
            // register write; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ABSENT_THRESHOLD: cfg.absent_threshold = i_cfg_data;
                    CFG_PRESENT_CONFIRM:  cfg.present_confirm  = i_cfg_data;
                    CFG_ABSENT_CONFIRM:   cfg.absent_confirm   = i_cfg_data;
                    CFG_WEIGHT_ULTRA:     cfg.weight_ultra     = i_cfg_data[WEIGHT_W-1:0];
                    CFG_WEIGHT_TOF:       cfg.weight_tof       = i_cfg_data[WEIGHT_W-1:0];
                    CFG_WEIGHT_PRESS:     cfg.weight_press     = i_cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // result against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (fused_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              result_count));
                end else begin
                    want = fused_q.pop_front();
                    compare_field("seat_occupied", i_seat_occupied, want.seated);
                    compare_field("weighted_sum", i_weighted_sum, want.wsum);
                    compare_field("sonar_cm_filtered", i_sonar_cm_filtered, want.ultra_f);
                    compare_field("tof_cm_filtered", i_tof_cm_filtered, want.tof_f);
                    compare_field("press_g_filtered", i_press_g_filtered, want.press_f);
                    compare_field("score_ultra_out", i_score_ultra_out, want.score_u);
                    compare_field("score_tof_out", i_score_tof_out, want.score_t);
                    compare_field("score_press_out", i_score_press_out, want.score_p);
                    compare_field("press_adc_average", i_press_adc_average, want.avg);
                end
                result_count++;
            end

            // accepted request
            if (i_in_valid && i_in_ready) begin
                req.sonar_mm    = i_sonar_mm;
                req.tof_mm      = i_tof_mm;
                req.press_raw   = {i_press_raw_c, i_press_raw_b, i_press_raw_a};
                req.press_valid = {i_press_valid_c, i_press_valid_b, i_press_valid_a};
                fuse_sample(req, fresh);
                fused_q.push_back(fresh);
            end
        end
        o_pending = fused_q.size();
    end

endmodule

>>> verif/seat_occupancy_sensor_fusion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_occupancy_sensor_fusion_test
// Test top for the seat occupancy fusion block. It drives band-edge requests,
// then phases of random sit-down / leave sequences under several register
// settings. Both channels idle at random, and the receiver holds off once for
// a long stretch. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module seat_occupancy_sensor_fusion_test;
    import sof_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 8;
    localparam int LONG_HOLD    = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [SONAR_MM_W-1:0] i_sonar_mm;
    logic [TOF_MM_W-1:0]   i_tof_mm;
    logic [ADC_W-1:0]      i_press_raw_a;
    logic                  i_press_valid_a;
    logic [ADC_W-1:0]      i_press_raw_b;
    logic                  i_press_valid_b;
    logic [ADC_W-1:0]      i_press_raw_c;
    logic                  i_press_valid_c;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_seat_occupied;
    logic [SUM_W-1:0]      o_weighted_sum;
    logic [UCM_W-1:0]      o_sonar_cm_filtered;
    logic [TCM_W-1:0]      o_tof_cm_filtered;
    logic [GRAM_W-1:0]     o_press_g_filtered;
    logic [SCORE_W-1:0]    o_score_ultra_out;
    logic [SCORE_W-1:0]    o_score_tof_out;
    logic [SCORE_W-1:0]    o_score_press_out;
    logic [ADC_W-1:0]      o_press_adc_average;

    int          failures;
    int          pending;
    int unsigned cycle_count = 0;
    bit          hold_sink   = 1'b0;

    seat_occupancy_sensor_fusion dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sonar_mm          (i_sonar_mm),
        .i_tof_mm            (i_tof_mm),
        .i_press_raw_a       (i_press_raw_a),
        .i_press_valid_a     (i_press_valid_a),
        .i_press_raw_b       (i_press_raw_b),
        .i_press_valid_b     (i_press_valid_b),
        .i_press_raw_c       (i_press_raw_c),
        .i_press_valid_c     (i_press_valid_c),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_seat_occupied     (o_seat_occupied),
        .o_weighted_sum      (o_weighted_sum),
        .o_sonar_cm_filtered (o_sonar_cm_filtered),
        .o_tof_cm_filtered   (o_tof_cm_filtered),
        .o_press_g_filtered  (o_press_g_filtered),
        .o_score_ultra_out   (o_score_ultra_out),
        .o_score_tof_out     (o_score_tof_out),
        .o_score_press_out   (o_score_press_out),
        .o_press_adc_average (o_press_adc_average)
    );

    seat_occupancy_sensor_fusion_checker checker_0 (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_sonar_mm          (i_sonar_mm),
        .i_tof_mm            (i_tof_mm),
        .i_press_raw_a       (i_press_raw_a),
        .i_press_valid_a     (i_press_valid_a),
        .i_press_raw_b       (i_press_raw_b),
        .i_press_valid_b     (i_press_valid_b),
        .i_press_raw_c       (i_press_raw_c),
        .i_press_valid_c     (i_press_valid_c),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_seat_occupied     (o_seat_occupied),
        .i_weighted_sum      (o_weighted_sum),
        .i_sonar_cm_filtered (o_sonar_cm_filtered),
        .i_tof_cm_filtered   (o_tof_cm_filtered),
        .i_press_g_filtered  (o_press_g_filtered),
        .i_score_ultra_out   (o_score_ultra_out),
        .i_score_tof_out     (o_score_tof_out),
        .i_score_press_out   (o_score_press_out),
        .i_press_adc_average (o_press_adc_average),
        .o_failures          (failures),
        .o_pending           (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result sink: random back-pressure, one long hold on request
    initial begin : result_sink
        int unsigned on_len;
        int unsigned off_len;
        int unsigned calm_left;
        bit          hold_served;
        calm_left   = 0;
        hold_served = 1'b0;
        i_ready     = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_sink && !hold_served) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_served = 1'b1;
            end
            i_ready <= 1'b1;
            on_len = $urandom_range(1, 16);
            repeat (on_len) @(negedge i_clk);
            if (calm_left == 0 && $urandom_range(0, 29) == 0)
                calm_left = $urandom_range(10, 40);
            if (calm_left > 0) begin
                calm_left--;
                off_len = 0;
            end else begin
                off_len = idle_gap();
            end
            if (off_len > 0) begin
                i_ready <= 1'b0;
                repeat (off_len) @(negedge i_clk);
            end
        end
    end

    // one request; entered and left at a falling edge
    task automatic send_sample(input logic [SONAR_MM_W-1:0] ultra,
                               input logic [TOF_MM_W-1:0] tof,
                               input logic [ADC_W-1:0] raw_a, input logic va,
                               input logic [ADC_W-1:0] raw_b, input logic vb,
                               input logic [ADC_W-1:0] raw_c, input logic vc,
                               input int unsigned gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sonar_mm      <= ultra;
        i_tof_mm        <= tof;
        i_press_raw_a   <= raw_a;
        i_press_valid_a <= va;
        i_press_raw_b   <= raw_b;
        i_press_valid_b <= vb;
        i_press_raw_c   <= raw_c;
        i_press_valid_c <= vc;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // two equal requests put the value in the middle of the window
    task automatic send_pair(input logic [SONAR_MM_W-1:0] ultra,
                             input logic [TOF_MM_W-1:0] tof, input logic [ADC_W-1:0] adc);
        repeat (2) send_sample(ultra, tof, adc, 1'b1, adc, 1'b1, adc, 1'b1, idle_gap());
    endtask

    // stop offering until every prediction has been matched
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // main sequence
    initial begin : stimulus
        logic [CFG_W-1:0]      thr;
        logic [CFG_W-1:0]      pconf;
        logic [CFG_W-1:0]      aconf;
        logic [WEIGHT_W-1:0]   wu;
        logic [WEIGHT_W-1:0]   wt;
        logic [WEIGHT_W-1:0]   wp;
        logic [SONAR_MM_W-1:0] ultra;
        logic [TOF_MM_W-1:0]   tof;
        logic [ADC_W-1:0]      raw [3];
        logic [2:0]            vflag;
        int unsigned           per_phase;
        int unsigned           stretch_left;
        int unsigned           roll;
        int unsigned           gap;
        bit                    occupied;
        bit                    calm;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_sonar_mm      = '0;
        i_tof_mm        = '0;
        i_press_raw_a   = '0;
        i_press_valid_a = 1'b0;
        i_press_raw_b   = '0;
        i_press_valid_b = 1'b0;
        i_press_raw_c   = '0;
        i_press_valid_c = 1'b0;
        per_phase       = RANDOM_ITEMS / PHASES;
        stretch_left    = 0;
        occupied        = 1'b0;
        calm            = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // band edges under the reset register values
        send_pair(12'd0,    16'd0,     12'd0);
        send_pair(12'd19,   16'd49,    12'd81);
        send_pair(12'd20,   16'd50,    12'd82);
        send_pair(12'd79,   16'd129,   12'd818);
        send_pair(12'd80,   16'd130,   12'd819);
        send_pair(12'd119,  16'd159,   12'd1637);
        send_pair(12'd120,  16'd160,   12'd1638);
        send_pair(12'd149,  16'd179,   12'd4095);
        send_pair(12'd150,  16'd180,   12'd4000);
        send_pair(12'd4000, 16'd65535, 12'd2000);
        // ultrasonic value above the sensor range
        send_pair(12'd4095, 16'd12345, 12'd100);
        // held samples: only some channels carry a new value
        send_sample(12'd60, 16'd90, 12'd4095, 1'b1, 12'd7, 1'b0, 12'd4095, 1'b0, 0);
        send_sample(12'd60, 16'd90, 12'd3, 1'b0, 12'd4095, 1'b0, 12'd2222, 1'b1, 0);
        send_sample(12'd60, 16'd90, 12'd1234, 1'b0, 12'd4000, 1'b0, 12'd9, 1'b0, 0);

        for (int p = 0; p < PHASES; p++) begin
            // settings change only with the block empty
            wait_drained();
            case (p)
                0: begin thr = 8'd255; pconf = 8'd255; aconf = 8'd255;
                         wu = 4'd15; wt = 4'd15; wp = 4'd15; end
                // zero confirm count always confirms seated
                1: begin thr = 8'd0; pconf = 8'd0; aconf = 8'd0;
                         wu = 4'd0; wt = 4'd0; wp = 4'd0; end
                2: begin thr = 8'd10; pconf = 8'd1; aconf = 8'd1;
                         wu = 4'd3; wt = 4'd3; wp = 4'd4; end
                3: begin thr = 8'd0; pconf = 8'd2; aconf = 8'd5;
                         wu = 4'd15; wt = 4'd0; wp = 4'd15; end
                default: begin
                    thr   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 60));
                    pconf = 8'($urandom_range(1, 8));
                    aconf = 8'($urandom_range(1, 8));
                    wu    = 4'($urandom_range(0, 15));
                    wt    = 4'($urandom_range(0, 15));
                    wp    = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_ABSENT_THRESHOLD, thr);
            write_reg(CFG_PRESENT_CONFIRM, pconf);
            write_reg(CFG_ABSENT_CONFIRM, aconf);
            // upper nibble must be dropped for weights
            write_reg(CFG_WEIGHT_ULTRA, {4'($urandom_range(0, 15)), wu});
            write_reg(CFG_WEIGHT_TOF, {4'($urandom_range(0, 15)), wt});
            write_reg(CFG_WEIGHT_PRESS, {4'($urandom_range(0, 15)), wp});
            // index past the register file: ignored
            write_reg(CFG_IDX_W'($urandom_range(6, 7)), 8'($urandom));

            for (int n = 0; n < per_phase; n++) begin
                if (n % 25 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (p == 4 && n == 50)
                    hold_sink = 1'b1;

                // sit-down / leave stretches with some noise in between
                if (stretch_left == 0) begin
                    occupied     = 1'($urandom_range(0, 1));
                    stretch_left = $urandom_range(1, 12);
                end
                stretch_left--;
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    ultra = SONAR_MM_W'($urandom);
                    tof   = TOF_MM_W'($urandom);
                    for (int k = 0; k < 3; k++) raw[k] = ADC_W'($urandom);
                end else if (occupied) begin
                    ultra = SONAR_MM_W'($urandom_range(15, 160));
                    tof   = TOF_MM_W'($urandom_range(40, 190));
                    for (int k = 0; k < 3; k++) raw[k] = ADC_W'($urandom_range(700, 4095));
                end else begin
                    ultra = (roll < 25) ? 12'd0 : 12'($urandom_range(150, 4095));
                    tof   = TOF_MM_W'($urandom_range(170, 65535));
                    for (int k = 0; k < 3; k++) raw[k] = ADC_W'($urandom_range(0, 400));
                end
                for (int k = 0; k < 3; k++) vflag[k] = ($urandom_range(0, 3) != 0);
                gap = calm ? 0 : idle_gap();
                send_sample(ultra, tof, raw[0], vflag[0], raw[1], vflag[1],
                            raw[2], vflag[2], gap);
            end
        end

        // drain, then give stray results time to show
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/sof_pkg.sv
rtl/core/sof_convert.sv
rtl/core/sof_filter.sv
rtl/core/sof_decide.sv
rtl/core/seat_occupancy_sensor_fusion.sv
rtl/core/sof_checker.sv
verif/seat_occupancy_sensor_fusion_checker.sv
verif/seat_occupancy_sensor_fusion_test.sv
